// ===== src/triangle_batch_vertex_remapper_core_macros.svh =====
// ----------------------------------------------------------------------------
// Triangle batch vertex remapper assertion macros
// Shared concurrent assertion forms for the remapper modules. Each use needs
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BATCH_VERTEX_REMAPPER_CORE_MACROS_SVH
`define TRIANGLE_BATCH_VERTEX_REMAPPER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBVR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tbvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle batch vertex remapper package
// Payload types, function and result codes, tag constants and the command
// that passes from the front end to the result sequencer.
// ----------------------------------------------------------------------------
package tbvr_pkg;

    // input function codes
    localparam logic [2:0] FUNC_BEGIN = 3'd0;
    localparam logic [2:0] FUNC_GROUP = 3'd1;
    localparam logic [2:0] FUNC_TRI   = 3'd2;
    localparam logic [2:0] FUNC_FLUSH = 3'd3;
    localparam logic [2:0] FUNC_END   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_TAG  = 2'd0;
    localparam logic [1:0] KIND_COPY = 2'd1;
    localparam logic [1:0] KIND_TRI  = 2'd2;

    // tag word fields
    localparam logic [31:0] TAG_GROUP      = 32'h8000_0000;
    localparam logic [31:0] TAG_INDEX      = 32'h2000_0000;
    localparam logic [31:0] TAG_END        = 32'hC000_0000;
    localparam logic [31:0] GROUP_MASK     = 32'h00FF_FFFF;

    // result slots of one command, emitted lowest first
    localparam int RES_TAG0  = 0;
    localparam int RES_TAG1  = 1;
    localparam int RES_COPY0 = 2;
    localparam int RES_TRI   = 5;
    localparam int RES_NUM   = 6;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  func;
        logic [23:0] group_index;
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
        logic [15:0] vertex_c;
    } tbvr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] word_pos;
        logic [31:0] tag_word;
        logic [15:0] source_vertex;
        logic [15:0] target_vertex;
        logic [15:0] index_pos;
        logic [5:0]  local_a;
        logic [5:0]  local_b;
        logic [5:0]  local_c;
        logic        last;
    } tbvr_out_t;

    typedef struct packed {
        logic [RES_NUM-1:0] mask;
        logic [15:0]        word_pos;
        logic [31:0]        tag0;
        logic [31:0]        tag1;
        logic [2:0][15:0]   src;
        logic [2:0][15:0]   target;
        logic [15:0]        index_pos;
        logic [2:0][5:0]    slot;
    } tbvr_cmd_t;

endpackage

// ===== src/tbvr_cam.sv =====
// ----------------------------------------------------------------------------
// Batch source table
// Flip-flop table of the batch's source vertices with one comparator per
// entry and corner; registered match vectors, masked to entries in use.
// ----------------------------------------------------------------------------
module tbvr_cam #(
    parameter int BATCH_VERTICES = 64
) (
    input  logic                                       clk,
    input  logic [2:0]                                 we,
    input  logic [2:0][$clog2(BATCH_VERTICES)-1:0]     waddr,
    input  logic [2:0][15:0]                           wdata,
    input  logic [2:0][15:0]                           key,
    input  logic [$clog2(BATCH_VERTICES + 3)-1:0]      count,
    output logic [2:0][BATCH_VERTICES-1:0]             match
);

    localparam int SLOT_W = $clog2(BATCH_VERTICES);
    localparam int CNT_W  = $clog2(BATCH_VERTICES + 3);

    logic [15:0]                        tbl_reg [BATCH_VERTICES];
    logic [2:0][BATCH_VERTICES-1:0]     match_next;
    logic [2:0][BATCH_VERTICES-1:0]     match_reg;

    // inserted corners always target distinct slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BATCH_VERTICES; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (we[k] && waddr[k] == SLOT_W'(i))
                begin
                    tbl_reg[i] <= wdata[k];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < BATCH_VERTICES; i++)
            begin
                match_next[k][i] = (CNT_W'(i) < count) && (tbl_reg[i] == key[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign match = match_reg;

endmodule

// ===== src/tbvr_front.sv =====
// ----------------------------------------------------------------------------
// Remapper front end
// Accepts items, looks up corners, decides flushes, allocates slots, keeps
// the batch counters and hands a command to the queue for each item with results.
// ----------------------------------------------------------------------------
`include "triangle_batch_vertex_remapper_core_macros.svh"

module tbvr_front #(
    parameter int BATCH_VERTICES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tbvr_pkg::tbvr_in_t     req,
    output logic                   cmd_push,
    output tbvr_pkg::tbvr_cmd_t    cmd,
    input  logic                   cmd_full
);

    localparam int SLOT_W = $clog2(BATCH_VERTICES);
    localparam int CNT_W  = $clog2(BATCH_VERTICES + 3);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MATCH  = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_PUSH   = 4'b1000
    } front_state_t;

    front_state_t                    state_reg, state_next;
    tbvr_pkg::tbvr_in_t              item_reg, item_next;
    tbvr_pkg::tbvr_cmd_t             cmd_reg, cmd_next;
    logic [2:0]                      ins_reg, ins_next;
    logic [2:0][CNT_W-1:0]           loc_reg, loc_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [15:0]                     vbase_reg, vbase_next;
    logic [15:0]                     tri_reg, tri_next;
    logic [15:0]                     ibase_reg, ibase_next;
    logic [15:0]                     wpos_reg, wpos_next;

    logic [2:0][15:0]                key;
    logic [2:0][BATCH_VERTICES-1:0]  match;
    logic [2:0]                      we;
    logic [2:0][SLOT_W-1:0]          waddr;

    logic [2:0]                      hit;
    logic [2:0]                      miss;
    logic [2:0][CNT_W-1:0]           slot;
    logic [2:0][CNT_W-1:0]           loc;
    logic [1:0]                      added;
    logic [CNT_W:0]                  demand;
    logic                            need;
    logic                            batch_busy;
    logic                            flush_do;
    logic [15:0]                     vbase_f;
    logic [15:0]                     ibase_f;
    logic [15:0]                     tri_f;
    logic [CNT_W-1:0]                c0, c1, c2, c3;
    logic [5:0]                      cnt_m1;
    logic [31:0]                     tag_vr;
    logic [31:0]                     tag_ir;
    logic                            count_ok;

    assign key = {item_reg.vertex_c, item_reg.vertex_b, item_reg.vertex_a};

    // slots past the table end get no entry
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            we[k]    = (state_reg == ST_PUSH) && ins_reg[k] &&
                       (loc_reg[k] < CNT_W'(BATCH_VERTICES));
            waddr[k] = SLOT_W'(loc_reg[k]);
        end
    end

    tbvr_cam #(
        .BATCH_VERTICES (BATCH_VERTICES)
    ) u_cam (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (key),
        .key   (key),
        .count (count_reg),
        .match (match)
    );

    // lookup results and slot allocation
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hit[k]  = |match[k];
            slot[k] = '0;
            for (int i = BATCH_VERTICES - 1; i >= 0; i--)
            begin
                if (match[k][i])
                begin
                    slot[k] = CNT_W'(i);
                end
            end
        end

        added      = 2'(!hit[0]) + 2'(!hit[1]) + 2'(!hit[2]);
        demand     = {1'b0, count_reg} + (CNT_W+1)'(added);
        need       = demand >= (CNT_W+1)'(BATCH_VERTICES);
        batch_busy = tri_reg != '0;
        flush_do   = need && batch_busy;

        // a full batch turns every corner into a new entry
        miss    = need ? 3'b111 : ~hit;
        vbase_f = flush_do ? vbase_reg + 16'(count_reg) : vbase_reg;
        ibase_f = flush_do ? ibase_reg + tri_reg : ibase_reg;
        tri_f   = flush_do ? 16'd0 : tri_reg;
        c0      = flush_do ? '0 : count_reg;

        loc[0] = miss[0] ? c0 : slot[0];
        c1     = c0 + CNT_W'(miss[0]);
        loc[1] = miss[1] ? c1 : slot[1];
        c2     = c1 + CNT_W'(miss[1]);
        loc[2] = miss[2] ? c2 : slot[2];
        c3     = c2 + CNT_W'(miss[2]);

        cnt_m1 = 6'(count_reg) - 6'd1;
        tag_vr = {10'd0, cnt_m1, vbase_reg};
        tag_ir = tbvr_pkg::TAG_INDEX | {9'd0, tri_reg[6:0], ibase_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cmd_next   = cmd_reg;
        ins_next   = ins_reg;
        loc_next   = loc_reg;
        count_next = count_reg;
        vbase_next = vbase_reg;
        tri_next   = tri_reg;
        ibase_next = ibase_reg;
        wpos_next  = wpos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next        = ST_PUSH;
                cmd_next          = '0;
                cmd_next.word_pos = wpos_reg;
                ins_next          = 3'b000;
                loc_next          = loc;
                case (item_reg.func)
                    tbvr_pkg::FUNC_BEGIN:
                    begin
                        count_next = '0;
                        vbase_next = '0;
                        tri_next   = '0;
                        ibase_next = '0;
                        wpos_next  = '0;
                    end
                    tbvr_pkg::FUNC_GROUP:
                    begin
                        cmd_next.mask[tbvr_pkg::RES_TAG0] = 1'b1;
                        cmd_next.tag0 = tbvr_pkg::TAG_GROUP |
                                        ({8'd0, item_reg.group_index} & tbvr_pkg::GROUP_MASK);
                        wpos_next = wpos_reg + 16'd1;
                    end
                    tbvr_pkg::FUNC_TRI:
                    begin
                        cmd_next.mask[tbvr_pkg::RES_TAG0]     = flush_do;
                        cmd_next.mask[tbvr_pkg::RES_TAG1]     = flush_do;
                        cmd_next.mask[tbvr_pkg::RES_COPY0 +: 3] = miss;
                        cmd_next.mask[tbvr_pkg::RES_TRI]      = 1'b1;
                        cmd_next.tag0      = tag_vr;
                        cmd_next.tag1      = tag_ir;
                        cmd_next.src       = key;
                        cmd_next.index_pos = ibase_f + tri_f;
                        for (int k = 0; k < 3; k++)
                        begin
                            cmd_next.target[k] = vbase_f + 16'(loc[k]);
                            cmd_next.slot[k]   = 6'(loc[k]);
                        end
                        ins_next   = miss;
                        count_next = c3;
                        vbase_next = vbase_f;
                        ibase_next = ibase_f;
                        tri_next   = tri_f + 16'd1;
                        if (flush_do)
                        begin
                            wpos_next = wpos_reg + 16'd2;
                        end
                    end
                    tbvr_pkg::FUNC_FLUSH:
                    begin
                        // an empty batch flushes to nothing
                        if (batch_busy)
                        begin
                            cmd_next.mask[tbvr_pkg::RES_TAG0] = 1'b1;
                            cmd_next.mask[tbvr_pkg::RES_TAG1] = 1'b1;
                            cmd_next.tag0 = tag_vr;
                            cmd_next.tag1 = tag_ir;
                            vbase_next    = vbase_reg + 16'(count_reg);
                            ibase_next    = ibase_reg + tri_reg;
                            count_next    = '0;
                            tri_next      = '0;
                            wpos_next     = wpos_reg + 16'd2;
                        end
                    end
                    tbvr_pkg::FUNC_END:
                    begin
                        cmd_next.mask[tbvr_pkg::RES_TAG0] = 1'b1;
                        cmd_next.tag0 = tbvr_pkg::TAG_END;
                        wpos_next     = wpos_reg + 16'd1;
                    end
                    default:
                    begin
                        cmd_next.mask = '0;
                    end
                endcase
            end
            ST_PUSH:
            begin
                // hold until the queue takes the command, unless it has no results; table writes repeat harmlessly
                if (cmd_reg.mask == '0 || !cmd_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            vbase_reg <= '0;
            tri_reg   <= '0;
            ibase_reg <= '0;
            wpos_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            vbase_reg <= vbase_next;
            tri_reg   <= tri_next;
            ibase_reg <= ibase_next;
            wpos_reg  <= wpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cmd_reg  <= cmd_next;
        ins_reg  <= ins_next;
        loc_reg  <= loc_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign cmd_push  = (state_reg == ST_PUSH) && (cmd_reg.mask != '0) && !cmd_full;
    assign cmd       = cmd_reg;
    // the count passes the table size only when a wrapped triangle count skips a flush
    assign count_ok  = count_reg <= CNT_W'(BATCH_VERTICES + 2);

    `TBVR_ASSERT_SAME(a_count_below_limit, 1'b1, count_ok, "batch vertex count reached limit")
    `TBVR_ASSERT_NEXT(a_push_returns_idle, cmd_push, state_reg == ST_IDLE,
                      "front end held after command push")

endmodule

// ===== src/tbvr_queue.sv =====
// ----------------------------------------------------------------------------
// Remapper command queue
// Short FIFO of commands between the front end and the result sequencer.
// ----------------------------------------------------------------------------
`include "triangle_batch_vertex_remapper_core_macros.svh"

module tbvr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tbvr_pkg::tbvr_cmd_t    push_data,
    output logic                   full,
    input  logic                   pop,
    output tbvr_pkg::tbvr_cmd_t    pop_data,
    output logic                   empty
);

    tbvr_pkg::tbvr_cmd_t              mem_reg [tbvr_pkg::QUEUE_DEPTH];
    logic [tbvr_pkg::QPTR_W-1:0]      wr_reg, wr_next;
    logic [tbvr_pkg::QPTR_W-1:0]      rd_reg, rd_next;
    logic [tbvr_pkg::QCNT_W-1:0]      fill_reg, fill_next;

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_next = (wr_reg == tbvr_pkg::QPTR_W'(tbvr_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == tbvr_pkg::QPTR_W'(tbvr_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : rd_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign full     = fill_reg == tbvr_pkg::QCNT_W'(tbvr_pkg::QUEUE_DEPTH);
    assign empty    = fill_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    `TBVR_ASSERT_SAME(a_no_push_when_full, push, !full, "command pushed into full queue")
    `TBVR_ASSERT_SAME(a_no_pop_when_empty, pop, !empty, "command popped from empty queue")

endmodule

// ===== src/tbvr_back.sv =====
// ----------------------------------------------------------------------------
// Remapper result sequencer
// Pops commands and emits their results one per cycle while the receiver is ready,
// through an output register, lowest result slot first, marking the last one.
// ----------------------------------------------------------------------------
`include "triangle_batch_vertex_remapper_core_macros.svh"

module tbvr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tbvr_pkg::tbvr_cmd_t    head,
    input  logic                   empty,
    output logic                   pop,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output tbvr_pkg::tbvr_out_t    rsp
);

    tbvr_pkg::tbvr_cmd_t              cmd_reg, cmd_next;
    logic [tbvr_pkg::RES_NUM-1:0]     pend_reg, pend_next;
    tbvr_pkg::tbvr_out_t              out_reg, out_next;
    logic                             out_valid_reg, out_valid_next;

    logic [tbvr_pkg::RES_NUM-1:0]     low;
    logic [tbvr_pkg::RES_NUM-1:0]     rest;
    logic [tbvr_pkg::RES_NUM-1:0]     pend_after;
    logic                             can_emit;
    tbvr_pkg::tbvr_out_t              res;

    assign low        = pend_reg & (~pend_reg + 1'b1);
    assign rest       = pend_reg & ~low;
    assign can_emit   = (pend_reg != '0) && (!out_valid_reg || rsp_ready);
    assign pend_after = can_emit ? rest : pend_reg;
    assign pop        = (pend_after == '0) && !empty;

    // build the result for the lowest pending slot
    always_comb
    begin
        res          = '0;
        res.word_pos = cmd_reg.word_pos;
        res.last     = rest == '0;
        if (low[tbvr_pkg::RES_TAG0])
        begin
            res.kind     = tbvr_pkg::KIND_TAG;
            res.tag_word = cmd_reg.tag0;
        end
        else if (low[tbvr_pkg::RES_TAG1])
        begin
            res.kind     = tbvr_pkg::KIND_TAG;
            res.word_pos = cmd_reg.word_pos + 16'd1;
            res.tag_word = cmd_reg.tag1;
        end
        else if (low[tbvr_pkg::RES_TRI])
        begin
            res.word_pos  = '0;
            res.kind      = tbvr_pkg::KIND_TRI;
            res.index_pos = cmd_reg.index_pos;
            res.local_a   = cmd_reg.slot[0];
            res.local_b   = cmd_reg.slot[1];
            res.local_c   = cmd_reg.slot[2];
        end
        else
        begin
            res.word_pos = '0;
            res.kind     = tbvr_pkg::KIND_COPY;
            for (int k = 0; k < 3; k++)
            begin
                if (low[tbvr_pkg::RES_COPY0 + k])
                begin
                    res.source_vertex = cmd_reg.src[k];
                    res.target_vertex = cmd_reg.target[k];
                end
            end
        end
    end

    always_comb
    begin
        cmd_next       = pop ? head : cmd_reg;
        pend_next      = pop ? head.mask : pend_after;
        out_next       = can_emit ? res : out_reg;
        out_valid_next = out_valid_reg;
        if (can_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `TBVR_ASSERT_NEXT(a_loaded_cmd_has_work, pop, pend_reg != '0,
                      "command without results taken from queue")

endmodule

// ===== src/triangle_batch_vertex_remapper_core.sv =====
// ----------------------------------------------------------------------------
// Triangle batch vertex remapper
// Splits triangles into batches, remaps corners to batch slots and emits
// copy requests, local index triples and packed tag words.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one function item; rsp channel
//   (rsp_valid/rsp_ready/rsp) returns zero to six results per item in order,
//   with rsp.last on the final one. Items with no results return nothing.
//   The front end takes each item through accept, table compare, decide and
//   allocate, and hand-off to the command queue; req_ready is high again once
//   the hand-off step is done, which waits for room in the queue. The sequencer
//   emits one result per cycle while the receiver is ready.
//   Reset clears the batch counters, positions, queue and output register.
//   The source table is not cleared: entries are only compared below the
//   batch vertex count, so there is no clearing pass.
//   A stalled receiver holds the result register; the queue then fills and
//   req_ready drops until results drain.
// ----------------------------------------------------------------------------
module triangle_batch_vertex_remapper_core #(
    parameter int BATCH_VERTICES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tbvr_pkg::tbvr_in_t     req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output tbvr_pkg::tbvr_out_t    rsp
);

    logic                   cmd_push;
    logic                   cmd_full;
    logic                   cmd_pop;
    logic                   cmd_empty;
    tbvr_pkg::tbvr_cmd_t    cmd_in;
    tbvr_pkg::tbvr_cmd_t    cmd_head;

    tbvr_front #(
        .BATCH_VERTICES (BATCH_VERTICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full)
    );

    tbvr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_head),
        .empty     (cmd_empty)
    );

    tbvr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (cmd_head),
        .empty     (cmd_empty),
        .pop       (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
